FILE: sv/ppd_pkg.sv
package ppd_pkg;

	// framing characters
	localparam logic [7:0] CHR_CR = 8'h0D;
	localparam logic [7:0] CHR_LF = 8'h0A;

	// deg * 0.01745 * 2^24 = mant * 349 * 2^(k-5) / 625, k = exponent - 126
	// mant * 349 * 512 / 625 = mant * 285 + mant * 563 / 625
	// floor(mant * 563 / 625) = (mant * REC_M) >> REC_SH, exact for any 24-bit mant
	localparam logic [8:0]  MUL_INT = 9'd285;
	localparam logic [32:0] REC_M   = 33'd7737813081;
	localparam int          REC_SH  = 33;
	localparam int          RPROD_W = 24 + REC_SH;

	localparam int PROD_W = 33;   // 24-bit mantissa times 349 * 512 / 625

	// angle classes
	localparam logic [1:0] CLS_NORM = 2'd0;
	localparam logic [1:0] CLS_ZERO = 2'd1;
	localparam logic [1:0] CLS_SAT  = 2'd2;

	typedef struct packed {
		logic frame_ok;   // closing byte of a good frame accepted this cycle
		logic cvt_start;  // angle word complete, start conversion
	} ppd_evt_t;

	typedef struct packed {
		logic busy;
		logic fin;
	} ppd_cvt_sts_t;

endpackage

FILE: sv/ppd_frame_fsm.sv
module ppd_frame_fsm #(
	parameter int PAYLOAD_BYTES = 24
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             acc,
	input  logic [7:0]       data_byte,
	output ppd_pkg::ppd_evt_t evt,
	output logic [31:0]      word0,
	output logic [31:0]      pos_x,
	output logic [31:0]      pos_y
);
	import ppd_pkg::*;

	localparam int CW = $clog2(PAYLOAD_BYTES);

	localparam logic [2:0] PH_HDR_CR  = 3'd0;
	localparam logic [2:0] PH_HDR_LF  = 3'd1;
	localparam logic [2:0] PH_PAYLOAD = 3'd2;
	localparam logic [2:0] PH_TRL_LF  = 3'd3;
	localparam logic [2:0] PH_TRL_CR  = 3'd4;

	logic [2:0]    phase_q;
	logic [CW-1:0] cnt_q;
	logic          start_q;
	logic [31:0]   word0_q;
	logic [31:0]   pos_x_q;
	logic [31:0]   pos_y_q;
	logic [CW-3:0] widx;
	logic [1:0]    lane;

	assign widx = cnt_q[CW-1:2];
	assign lane = cnt_q[1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HDR_CR;
			cnt_q   <= '0;
			start_q <= 1'b0;
		end else begin
			start_q <= acc && (phase_q == PH_PAYLOAD) && (cnt_q == CW'(3));
			if (acc) begin
				case (phase_q)
					PH_HDR_CR: begin
						phase_q <= (data_byte == CHR_CR) ? PH_HDR_LF : PH_HDR_CR;
					end
					PH_HDR_LF: begin
						if (data_byte == CHR_LF) begin
							phase_q <= PH_PAYLOAD;
							cnt_q   <= '0;
						end else if (data_byte != CHR_CR) begin
							phase_q <= PH_HDR_CR;
						end
					end
					PH_PAYLOAD: begin
						if (cnt_q == CW'(PAYLOAD_BYTES - 1)) begin
							cnt_q   <= '0;
							phase_q <= PH_TRL_LF;
						end else begin
							cnt_q <= cnt_q + 1'b1;
						end
					end
					PH_TRL_LF: begin
						phase_q <= (data_byte == CHR_LF) ? PH_TRL_CR : PH_HDR_CR;
					end
					default: begin
						phase_q <= PH_HDR_CR;
					end
				endcase
			end
		end
	end

	// only the three words that are used are kept
	always_ff @(posedge clk) begin
		if (acc && (phase_q == PH_PAYLOAD)) begin
			if (widx == (CW-2)'(0))
				word0_q[{lane, 3'b000} +: 8] <= data_byte;
			if (widx == (CW-2)'(3))
				pos_x_q[{lane, 3'b000} +: 8] <= data_byte;
			if (widx == (CW-2)'(4))
				pos_y_q[{lane, 3'b000} +: 8] <= data_byte;
		end
	end

	assign evt.frame_ok  = acc && (phase_q == PH_TRL_CR) && (data_byte == CHR_CR);
	assign evt.cvt_start = start_q;
	assign word0 = word0_q;
	assign pos_x = pos_x_q;
	assign pos_y = pos_y_q;

endmodule

FILE: sv/ppd_angle_cvt.sv
module ppd_angle_cvt (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [31:0]          angle_bits,
	output logic signed [31:0]   heading,
	output ppd_pkg::ppd_cvt_sts_t sts
);
	import ppd_pkg::*;

	logic [7:0]           expo;
	logic [22:0]          frac;
	logic [23:0]          mant;
	logic [1:0]           cls;
	logic [7:0]           sh;

	// stage valids: capture, multiply, sum, round
	logic [3:0]           vld_q;
	logic [23:0]          mant_q;
	logic                 neg_q;
	logic [1:0]           cls_q;
	logic [7:0]           sh_q;
	logic [23:0]          frc_q;
	logic [PROD_W-1:0]    whl_q;
	logic [PROD_W-1:0]    quo_q;
	logic signed [31:0]   heading_q;

	logic [RPROD_W-1:0]   rprod;
	logic [PROD_W:0]      rsum;
	logic [PROD_W:0]      mag;
	logic signed [31:0]   res;

	// decode: value = mant * 349 * 2^9 / 625 / 2^sh, sh = 140 - exponent
	assign expo = angle_bits[30:23];
	assign frac = angle_bits[22:0];
	assign mant = (expo == 8'd0) ? {1'b0, frac} : {1'b1, frac};
	assign sh   = (expo == 8'd0) ? 8'd139 : 8'd140 - expo;

	always_comb begin
		if (expo == 8'hFF)
			cls = (frac != 23'd0) ? CLS_ZERO : CLS_SAT;   // NaN gives zero
		else if (expo >= 8'd140)
			cls = CLS_SAT;
		else if (mant == 24'd0)
			cls = CLS_ZERO;
		else
			cls = CLS_NORM;
	end

	// division by 625 through the reciprocal
	assign rprod = RPROD_W'(mant_q) * RPROD_W'(REC_M);

	// round the magnitude half up (half away from zero) by the exponent shift, then saturate by sign
	always_comb begin
		rsum = '0;
		mag  = '0;
		if (sh_q != 8'd0 && sh_q <= 8'(PROD_W)) begin
			rsum = (PROD_W+1)'(quo_q) + ((PROD_W+1)'(1) << (sh_q - 8'd1));
			mag  = rsum >> sh_q;
		end
		case (cls_q)
			CLS_ZERO: res = 32'sd0;
			CLS_SAT:  res = neg_q ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
			default: begin
				if (neg_q)
					res = (mag >= (PROD_W+1)'(33'h0_8000_0000)) ? 32'sh8000_0000
						: -$signed(mag[31:0]);
				else
					res = (mag > (PROD_W+1)'(33'h0_7FFF_FFFF)) ? 32'sh7FFF_FFFF
						: $signed(mag[31:0]);
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[2:0], start};
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mant_q <= mant;
			neg_q  <= angle_bits[31];
			cls_q  <= cls;
			sh_q   <= sh;
		end
		if (vld_q[0]) begin
			frc_q <= rprod[RPROD_W-1:REC_SH];
			whl_q <= PROD_W'(mant_q) * PROD_W'(MUL_INT);
		end
		if (vld_q[1])
			quo_q <= whl_q + PROD_W'(frc_q);
		if (vld_q[2])
			heading_q <= res;
	end

	assign heading  = heading_q;
	assign sts.busy = |vld_q[2:0];
	assign sts.fin  = vld_q[3];

endmodule

FILE: sv/pose_packet_deframer.sv
// Channel | Dir | tdata (low bit up)                               | tuser
// s_*     | in  | data_byte[7:0]                                   | rezero
// m_*     | out | heading_abs, heading_rel, pos_x_bits, pos_y_bits | frame_done
//
// One result per input item; an item is taken every cycle while the output
// register is empty or being drained; the result is valid in the next cycle.
// The angle word is converted in the background from the fourth payload
// byte on: capture, reciprocal multiply for the division by 625, add and
// rounding; done well before the closing byte.
// Reset clears framing state, heading, positions and offset.
// A stalled output holds its item; the input then stalls too.
module pose_packet_deframer #(
	parameter int PAYLOAD_BYTES = 24
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,   // [7:0] data_byte
	input  logic         s_tuser,   // [0] rezero
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [127:0] m_tdata,   // [31:0] heading_abs, [63:32] heading_rel,
	                                // [95:64] pos_x_bits, [127:96] pos_y_bits
	output logic         m_tuser    // [0] frame_done
);
	import ppd_pkg::*;

	logic               acc;
	ppd_evt_t           evt;
	ppd_cvt_sts_t       cvt_sts;
	logic [31:0]        word0;
	logic [31:0]        cap_x;
	logic [31:0]        cap_y;
	logic signed [31:0] cvt_hdg;

	// architectural state
	logic signed [31:0] hdg_q;
	logic signed [31:0] hdg_off_q;
	logic [31:0]        pos_x_q;
	logic [31:0]        pos_y_q;

	// output register
	logic               out_vld_q;
	logic               out_done_q;
	logic [31:0]        out_abs_q;
	logic [31:0]        out_rel_q;
	logic [31:0]        out_x_q;
	logic [31:0]        out_y_q;

	logic signed [31:0] hdg_nx;
	logic [31:0]        pos_x_nx;
	logic [31:0]        pos_y_nx;
	logic signed [32:0] diff;
	logic [31:0]        rel;

	assign s_tready = !out_vld_q || m_tready;
	assign acc      = s_tvalid && s_tready;

	ppd_frame_fsm #(
		.PAYLOAD_BYTES(PAYLOAD_BYTES)
	) u_fsm (
		.clk      (clk),
		.arst_n   (arst_n),
		.acc      (acc),
		.data_byte(s_tdata),
		.evt      (evt),
		.word0    (word0),
		.pos_x    (cap_x),
		.pos_y    (cap_y)
	);

	ppd_angle_cvt u_cvt (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (evt.cvt_start),
		.angle_bits(word0),
		.heading   (cvt_hdg),
		.sts       (cvt_sts)
	);

	// values after this item
	assign hdg_nx   = evt.frame_ok ? cvt_hdg : hdg_q;
	assign pos_x_nx = evt.frame_ok ? cap_x : pos_x_q;
	assign pos_y_nx = evt.frame_ok ? cap_y : pos_y_q;

	// relative heading uses the offset from before this item
	assign diff = {hdg_nx[31], hdg_nx} - {hdg_off_q[31], hdg_off_q};
	always_comb begin
		if (diff[32] != diff[31])
			rel = diff[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
		else
			rel = diff[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdg_q     <= '0;
			hdg_off_q <= '0;
			pos_x_q   <= '0;
			pos_y_q   <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (acc) begin
				hdg_q     <= hdg_nx;
				pos_x_q   <= pos_x_nx;
				pos_y_q   <= pos_y_nx;
				out_vld_q <= 1'b1;
				if (s_tuser)
					hdg_off_q <= hdg_nx;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			out_done_q <= evt.frame_ok;
			out_abs_q  <= hdg_nx;
			out_rel_q  <= rel;
			out_x_q    <= pos_x_nx;
			out_y_q    <= pos_y_nx;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tuser  = out_done_q;
	assign m_tdata  = {out_y_q, out_x_q, out_rel_q, out_abs_q};

	// conversion must have settled before a frame closes
	a_cvt_ready: assert property (@(posedge clk) disable iff (!arst_n)
		evt.frame_ok |-> !cvt_sts.busy && !cvt_sts.fin)
		else $error("angle conversion still running at frame close");

	// every accepted item leaves a result in the output register
	a_out_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> m_tvalid)
		else $error("accepted item produced no result");

	// rezero captures the heading as it stands after the item
	a_rezero: assert property (@(posedge clk) disable iff (!arst_n)
		acc && s_tuser |=> hdg_off_q == hdg_q)
		else $error("offset capture mismatch");

endmodule

FILE: test/pose_packet_deframer_tb.sv
`timescale 1ns / 1ps

module pose_packet_deframer_tb;

	localparam int PAYLOAD    = 24;
	localparam int RAND_ITEMS = 1100;

	// degrees to 2^-24 rad: x * 0.01745 * 2^24 / 2^24 = x * 349 / 20000
	localparam longint unsigned DEG_SCALE_NUM = 64'd349;
	localparam longint unsigned DEG_SCALE_DEN = 64'd20000;

	localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

	localparam logic [7:0] CR = ppd_pkg::CHR_CR;
	localparam logic [7:0] LF = ppd_pkg::CHR_LF;

	// framing state of the local copy of the deframer
	typedef enum logic [2:0] {
		HUNT_CR  = 3'd0,
		HUNT_LF  = 3'd1,
		IN_BODY  = 3'd2,
		TRAIL_LF = 3'd3,
		TRAIL_CR = 3'd4
	} frame_phase_t;

	typedef enum int {ROW_BYTE, ROW_FRAME} row_kind_t;

	// how a frame ends
	typedef enum int {
		TRL_OK,         // LF CR
		TRL_BAD_OPEN,   // wrong first trailer byte
		TRL_BAD_CLOSE,  // LF then a wrong closing byte
		TRL_CR_OPEN     // CR where the LF belongs, nothing after
	} trailer_t;

	typedef struct packed {
		logic              done;
		logic signed [31:0] head_abs;
		logic signed [31:0] head_rel;
		logic [31:0]       pos_x;
		logic [31:0]       pos_y;
	} pose_t;

	typedef struct {
		row_kind_t   kind;
		int          ncr;      // CR bytes before the LF
		bit          hdr_bad;  // junk byte in place of the LF
		logic [31:0] angle;    // word 0; low byte is the item for ROW_BYTE
		logic [31:0] px;
		logic [31:0] py;
		trailer_t    trl;
		bit          rz;       // rezero on the row's last item
		bit          typed;    // 'want' replaces the predicted last result
		pose_t       want;
	} stim_row_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [7:0]   s_tdata;   // [7:0] data_byte
	logic         s_tuser;   // [0] rezero
	logic         m_tvalid;
	logic         m_tready;
	logic [127:0] m_tdata;   // [31:0] heading_abs, [63:32] heading_rel,
	                         // [95:64] pos_x_bits, [127:96] pos_y_bits
	logic         m_tuser;   // [0] frame_done

	// predictor state
	frame_phase_t       trk_phase;
	int                 trk_cnt;
	logic [7:0]         trk_buf [PAYLOAD];
	logic signed [31:0] trk_head;
	logic [31:0]        trk_x;
	logic [31:0]        trk_y;
	logic signed [31:0] trk_off;

	pose_t     pose_q [$];     // results still to come, oldest first
	stim_row_t stim_tab [$];

	int errors      = 0;
	int items_sent  = 0;
	int frames_seen = 0;
	int rezero_cnt  = 0;
	int src_pct     = 0;       // sender idle chance per cycle, percent
	int rx_pct      = 0;       // receiver stall chance per cycle, percent

	pose_packet_deframer #(
		.PAYLOAD_BYTES(PAYLOAD)
	) u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic bit chance(input int pct);
		return int'($urandom_range(99)) < pct;
	endfunction

	function automatic logic [7:0] rand_byte();
		logic [31:0] r;
		r = $urandom();
		return r[7:0];
	endfunction

	function automatic pose_t pose(input logic d, input logic [31:0] a, input logic [31:0] r,
	                               input logic [31:0] x, input logic [31:0] y);
		pose_t p;
		p.done     = d;
		p.head_abs = a;
		p.head_rel = r;
		p.pos_x    = x;
		p.pos_y    = y;
		return p;
	endfunction

	// clamp a sign and magnitude into signed 32 bits
	function automatic logic signed [31:0] clamp_q24(input logic neg, input longint unsigned mag);
		if (neg)
			return (mag >= 64'h8000_0000) ? Q_MIN : 32'sd0 - $signed(mag[31:0]);
		return (mag > 64'h7FFF_FFFF) ? Q_MAX : $signed(mag[31:0]);
	endfunction

	// IEEE single degrees -> 2^-24 rad, rounded half away from zero
	function automatic logic signed [31:0] deg_to_rad_q24(input logic [31:0] w);
		logic            neg;
		logic [7:0]      ex;
		logic [22:0]     fr;
		longint unsigned m, n, d, q, r;
		int              k;
		neg = w[31];
		ex  = w[30:23];
		fr  = w[22:0];
		if (ex == 8'hFF)
			return (fr != 23'd0) ? 32'sd0 : (neg ? Q_MIN : Q_MAX);
		if (ex == 8'd0) begin
			m = {41'd0, fr};
			k = -125;
		end else begin
			m = {40'd0, 1'b1, fr};
			k = int'(ex) - 126;
		end
		if (m == 0)
			return 32'sd0;
		n = m * DEG_SCALE_NUM;
		if (k >= 14)
			return clamp_q24(neg, 64'hF_FFFF_FFFF);
		if (k >= 0) begin
			n = n << k;
			d = DEG_SCALE_DEN;
		end else begin
			if (-k >= 40)
				return 32'sd0;
			d = DEG_SCALE_DEN << (-k);
		end
		q = n / d;
		r = n % d;
		if (2 * r >= d)
			q = q + 1;
		return clamp_q24(neg, q);
	endfunction

	function automatic logic [31:0] payload_word(input int idx);
		return {trk_buf[idx*4+3], trk_buf[idx*4+2], trk_buf[idx*4+1], trk_buf[idx*4]};
	endfunction

	// advance the local deframer by one byte, return the result it gives
	function automatic pose_t deframe_predict(input logic [7:0] b, input logic rz);
		logic   done;
		longint diff;
		pose_t  p;
		done = 1'b0;
		case (trk_phase)
			HUNT_CR: begin
				trk_phase = (b == CR) ? HUNT_LF : HUNT_CR;
			end
			HUNT_LF: begin
				if (b == LF) begin
					trk_phase = IN_BODY;
					trk_cnt   = 0;
				end else if (b != CR) begin
					trk_phase = HUNT_CR;
				end
			end
			IN_BODY: begin
				trk_buf[trk_cnt] = b;
				trk_cnt++;
				if (trk_cnt >= PAYLOAD) begin
					trk_cnt   = 0;
					trk_phase = TRAIL_LF;
				end
			end
			TRAIL_LF: begin
				trk_phase = (b == LF) ? TRAIL_CR : HUNT_CR;
			end
			TRAIL_CR: begin
				// a wrong closing byte leaves everything as it was
				if (b == CR) begin
					trk_head = deg_to_rad_q24(payload_word(0));
					trk_x    = payload_word(3);
					trk_y    = payload_word(4);
					done     = 1'b1;
				end
				trk_phase = HUNT_CR;
			end
			default: begin
				trk_phase = HUNT_CR;
			end
		endcase
		// relative heading uses the offset held before this item
		diff = longint'(trk_head) - longint'(trk_off);
		if (diff > longint'(Q_MAX))
			p.head_rel = Q_MAX;
		else if (diff < longint'(Q_MIN))
			p.head_rel = Q_MIN;
		else
			p.head_rel = diff[31:0];
		if (rz)
			trk_off = trk_head;
		p.done     = done;
		p.head_abs = trk_head;
		p.pos_x    = trk_x;
		p.pos_y    = trk_y;
		return p;
	endfunction

	// one item on the input side; entered and left at a falling edge
	task automatic send_item(input logic [7:0] b, input logic rz, input bit typed,
	                         input pose_t want);
		pose_t p;
		while (chance(src_pct)) begin
			s_tvalid <= 1'b0;
			s_tdata  <= rand_byte();
			s_tuser  <= chance(50);
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tuser  <= rz;
		do
			@(posedge clk);
		while (!s_tready);
		p = deframe_predict(b, rz);
		pose_q.push_back(typed ? want : p);
		items_sent++;
		if (rz)
			rezero_cnt++;
		@(negedge clk);
	endtask

	// header, payload with the pose words in place, then trailer
	task automatic send_frame(input int ncr, input bit hdr_bad, input logic [31:0] angle,
	                          input logic [31:0] px, input logic [31:0] py, input trailer_t trl,
	                          input bit rz_last, input int rz_pct, input bit typed,
	                          input pose_t want);
		logic [7:0] pl [PAYLOAD];
		logic [7:0] b;
		for (int i = 0; i < PAYLOAD; i++)
			pl[i] = rand_byte();
		{pl[3], pl[2], pl[1], pl[0]}     = angle;
		{pl[15], pl[14], pl[13], pl[12]} = px;
		{pl[19], pl[18], pl[17], pl[16]} = py;
		for (int i = 0; i < ncr; i++)
			send_item(CR, chance(rz_pct), 0, '0);
		if (hdr_bad) begin
			do
				b = rand_byte();
			while (b == CR || b == LF);
		end else begin
			b = LF;
		end
		send_item(b, chance(rz_pct), 0, '0);
		for (int i = 0; i < PAYLOAD; i++)
			send_item(pl[i], chance(rz_pct), 0, '0);
		case (trl)
			TRL_CR_OPEN: begin
				// CR must not count as the start of a new header
				send_item(CR, rz_last, typed, want);
			end
			TRL_BAD_OPEN: begin
				do
					b = rand_byte();
				while (b == LF);
				send_item(b, chance(rz_pct), 0, '0);
				send_item(rand_byte(), rz_last, typed, want);
			end
			TRL_BAD_CLOSE: begin
				send_item(LF, chance(rz_pct), 0, '0);
				do
					b = rand_byte();
				while (b == CR);
				send_item(b, rz_last, typed, want);
			end
			default: begin
				send_item(LF, chance(rz_pct), 0, '0);
				send_item(CR, rz_last, typed, want);
			end
		endcase
	endtask

	task automatic add_row(input row_kind_t kind, input int ncr, input bit hdr_bad,
	                       input logic [31:0] angle, input logic [31:0] px,
	                       input logic [31:0] py, input trailer_t trl, input bit rz,
	                       input bit typed, input pose_t want);
		stim_row_t r;
		r.kind    = kind;
		r.ncr     = ncr;
		r.hdr_bad = hdr_bad;
		r.angle   = angle;
		r.px      = px;
		r.py      = py;
		r.trl     = trl;
		r.rz      = rz;
		r.typed   = typed;
		r.want    = want;
		stim_tab.push_back(r);
	endtask

	// angle word for random frames: mostly plain angles, some specials
	function automatic logic [31:0] pick_angle();
		logic [31:0] w;
		logic [7:0]  ex;
		w = $urandom();
		case ($urandom_range(9))
			0: ;
			1: begin
				case ($urandom_range(7))
					0: w = 32'h7F80_0000;
					1: w = 32'hFF80_0000;
					2: w = {w[31], 8'hFF, w[22:1], 1'b1};
					3: w = {w[31], 31'd0};
					4: w = {w[31], 8'd0, w[22:0]};
					5: w = {w[31], 8'hFE, w[22:0]};
					6: w = {w[31], 31'h4100_02FF};
					default: w = {w[31], 8'd139, w[22:0]};
				endcase
			end
			default: begin
				ex = 8'($urandom_range(140, 100));
				w  = {w[31], ex, w[22:0]};
			end
		endcase
		return w;
	endfunction

	// receiver back-pressure
	always @(negedge clk)
		m_tready <= !chance(rx_pct);

	// result checking against the oldest expectation
	task automatic check_field(input string name, input logic [31:0] want,
	                           input logic [31:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s expected %h actual %h", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin : result_check
		pose_t w;
		if (arst_n && m_tvalid && m_tready) begin
			if (pose_q.size() == 0) begin
				errors++;
				$display("%0t: result with no item pending, expected none actual %h %h",
				         $time, m_tuser, m_tdata);
			end else begin
				w = pose_q.pop_front();
				check_field("frame_done", {31'd0, w.done}, {31'd0, m_tuser});
				check_field("heading_abs", w.head_abs, m_tdata[31:0]);
				check_field("heading_rel", w.head_rel, m_tdata[63:32]);
				check_field("pos_x_bits", w.pos_x, m_tdata[95:64]);
				check_field("pos_y_bits", w.pos_y, m_tdata[127:96]);
				if (m_tuser)
					frames_seen++;
			end
		end
	end

	// watchdog
	initial begin
		#5ms;
		$display("pose_packet_deframer_tb NOT OK");
		$finish;
	end

	initial begin : stimulus
		stim_row_t r;
		int        dir_items;
		int        ph;
		int        pick;
		trailer_t  trl;

		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = 8'd0;
		s_tuser   = 1'b0;
		trk_phase = HUNT_CR;
		trk_cnt   = 0;
		trk_head  = 32'sd0;
		trk_x     = 32'd0;
		trk_y     = 32'd0;
		trk_off   = 32'sd0;
		for (int i = 0; i < PAYLOAD; i++)
			trk_buf[i] = 8'd0;

		// after reset: nothing latched yet
		add_row(ROW_BYTE, 0, 0, 32'h00, 0, 0, TRL_OK, 0, 1, pose(0, 0, 0, 0, 0));
		add_row(ROW_BYTE, 0, 0, 32'hFF, 0, 0, TRL_OK, 0, 1, pose(0, 0, 0, 0, 0));
		// infinities saturate by sign; one and then three CRs before the LF
		add_row(ROW_FRAME, 1, 0, 32'h7F80_0000, 32'hFFFF_FFFF, 32'h0, TRL_OK, 0, 1,
		        pose(1, Q_MAX, Q_MAX, 32'hFFFF_FFFF, 32'h0));
		add_row(ROW_FRAME, 3, 0, 32'hFF80_0000, 32'h0, 32'hFFFF_FFFF, TRL_OK, 1, 1,
		        pose(1, Q_MIN, Q_MIN, 32'h0, 32'hFFFF_FFFF));
		// offset now at the negative limit: relative heading clamps high
		add_row(ROW_FRAME, 1, 0, 32'h7F7F_FFFF, 32'h3F80_0000, 32'hBF80_0000, TRL_OK, 0, 1,
		        pose(1, Q_MAX, Q_MAX, 32'h3F80_0000, 32'hBF80_0000));
		add_row(ROW_BYTE, 0, 0, 32'h5A, 0, 0, TRL_OK, 1, 1,
		        pose(0, Q_MAX, Q_MAX, 32'h3F80_0000, 32'hBF80_0000));
		// offset at the positive limit: relative heading clamps low
		add_row(ROW_FRAME, 2, 0, 32'hFF7F_FFFF, 32'h1234_5678, 32'h8765_4321, TRL_OK, 0, 1,
		        pose(1, Q_MIN, Q_MIN, 32'h1234_5678, 32'h8765_4321));
		// NaN gives zero
		add_row(ROW_FRAME, 1, 0, 32'h7FC0_0000, 32'hAAAA_AAAA, 32'h5555_5555, TRL_OK, 1, 1,
		        pose(1, 0, 32'h8000_0001, 32'hAAAA_AAAA, 32'h5555_5555));
		// negative zero gives zero
		add_row(ROW_FRAME, 1, 0, 32'h8000_0000, 32'h0123_4567, 32'h89AB_CDEF, TRL_OK, 0, 1,
		        pose(1, 0, 0, 32'h0123_4567, 32'h89AB_CDEF));
		// broken trailers and header
		add_row(ROW_FRAME, 2, 0, 32'h42B4_0000, 32'h1, 32'h2, TRL_BAD_OPEN, 0, 0, '0);
		add_row(ROW_FRAME, 1, 0, 32'h4334_0000, 32'h3, 32'h4, TRL_BAD_CLOSE, 1, 0, '0);
		add_row(ROW_FRAME, 1, 1, 32'h3F80_0000, 32'h5, 32'h6, TRL_OK, 0, 0, '0);
		// CR in place of the trailer LF, then a frame with no CR: not a frame
		add_row(ROW_FRAME, 1, 0, 32'h3F80_0000, 32'h7, 32'h8, TRL_CR_OPEN, 0, 0, '0);
		add_row(ROW_FRAME, 0, 0, 32'h4000_0000, 32'h9, 32'hA, TRL_OK, 0, 0, '0);
		// exact half-unit ties, both signs
		add_row(ROW_FRAME, 1, 0, 32'h4100_02FF, 32'hB, 32'hC, TRL_OK, 0, 0, '0);
		add_row(ROW_FRAME, 1, 0, 32'hC100_02FF, 32'hD, 32'hE, TRL_OK, 1, 0, '0);
		// denormals, saturation edge, ordinary angles
		add_row(ROW_FRAME, 1, 0, 32'h0000_0001, 32'hF, 32'h10, TRL_OK, 0, 0, '0);
		add_row(ROW_FRAME, 1, 0, 32'h807F_FFFF, 32'h11, 32'h12, TRL_OK, 0, 0, '0);
		add_row(ROW_FRAME, 2, 0, 32'h4600_0000, 32'h13, 32'h14, TRL_OK, 0, 0, '0);
		add_row(ROW_FRAME, 1, 0, 32'hC5E4_E000, 32'h15, 32'h16, TRL_OK, 0, 0, '0);
		add_row(ROW_FRAME, 1, 0, 32'h42B4_0000, 32'h17, 32'h18, TRL_OK, 1, 0, '0);
		add_row(ROW_FRAME, 1, 0, 32'h4334_0000, 32'h19, 32'h1A, TRL_OK, 0, 0, '0);

		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (stim_tab[i]) begin
			r = stim_tab[i];
			if (r.kind == ROW_BYTE)
				send_item(r.angle[7:0], r.rz, r.typed, r.want);
			else
				send_frame(r.ncr, r.hdr_bad, r.angle, r.px, r.py, r.trl, r.rz, 0, r.typed,
				           r.want);
		end
		dir_items = items_sent;

		// random part in four pressure phases
		while (items_sent < dir_items + RAND_ITEMS) begin
			ph = (items_sent - dir_items) * 4 / RAND_ITEMS;
			case (ph)
				0: begin src_pct = 0;  rx_pct = 0;  end
				1: begin src_pct = 58; rx_pct = 0;  end
				2: begin src_pct = 0;  rx_pct = 58; end
				default: begin src_pct = 16; rx_pct = 16; end
			endcase
			pick = $urandom_range(9);
			if (pick <= 6) begin
				send_frame($urandom_range(3, 1), 0, pick_angle(), $urandom(), $urandom(),
				           TRL_OK, chance(20), 4, 0, '0);
			end else if (pick == 7) begin
				trl = trailer_t'($urandom_range(3, 1));
				send_frame($urandom_range(2, 1), 0, pick_angle(), $urandom(), $urandom(),
				           trl, chance(20), 4, 0, '0);
			end else if (pick == 8) begin
				send_frame($urandom_range(2, 0), 1, pick_angle(), $urandom(), $urandom(),
				           TRL_OK, chance(20), 4, 0, '0);
			end else begin
				repeat ($urandom_range(8, 1))
					send_item(rand_byte(), chance(10), 0, '0);
			end
		end

		s_tvalid <= 1'b0;
		while (pose_q.size() != 0)
			@(posedge clk);
		// let any stray result show up
		repeat (40) @(posedge clk);
		if (pose_q.size() != 0) begin
			errors++;
			$display("%0t: results missing, expected %0d more actual 0", $time, pose_q.size());
		end

		$display("Sent %0d bytes (%0d rezero), %0d frames completed", items_sent, rezero_cnt,
		         frames_seen);
		$display("Phases: free running, sender gaps, receiver stalls, both; %0d mismatches",
		         errors);
		if (errors == 0)
			$display("pose_packet_deframer_tb OK");
		else
			$display("pose_packet_deframer_tb NOT OK");
		$finish;
	end

endmodule
